// ===== src/flash_block_receiver_unit_defines.svh =====
// Assertion macros for the flash block receiver.
`ifndef FLASH_BLOCK_RECEIVER_UNIT_DEFINES_SVH
`define FLASH_BLOCK_RECEIVER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FBR_ASSERT(label, clock, reset_n, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) prop) else $error(msg);
`define FBR_ASSERT_NEXT(label, clock, reset_n, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) else $error(msg);
`else
`define FBR_ASSERT(label, clock, reset_n, prop, msg)
`define FBR_ASSERT_NEXT(label, clock, reset_n, ante, cons, msg)
`endif
`endif

// ===== src/fbr_pkg.sv =====
package fbr_pkg;

    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_TIMEOUT = 2'd1;
    localparam logic [1:0] KIND_BEGIN   = 2'd2;

    localparam logic [2:0] ACT_SEND  = 3'd0;
    localparam logic [2:0] ACT_ERASE = 3'd1;
    localparam logic [2:0] ACT_FILL  = 3'd2;
    localparam logic [2:0] ACT_WRITE = 3'd3;
    localparam logic [2:0] ACT_START = 3'd4;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_X     = 8'h58;

    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = 1;

    typedef enum logic [1:0] {
        CMD_SEND   = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_START  = 2'd2,
        CMD_COMMIT = 2'd3
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [7:0]  tx;
        logic [15:0] addr;
        logic [7:0]  len;
    } cmd_t;

    typedef struct packed {
        logic       en;
        logic [7:0] idx;
        logic [7:0] data;
    } wr_t;

endpackage

// ===== src/fbr_queue.sv =====
module fbr_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fbr_pkg::cmd_t push_cmd,
    input  logic          pop,
    output fbr_pkg::cmd_t pop_cmd,
    output logic          full,
    output logic          empty
);

    fbr_pkg::cmd_t q_mem [fbr_pkg::Q_DEPTH];

    logic [fbr_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [fbr_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [fbr_pkg::QPTR_W:0]   count_reg, count_next;
    logic do_push, do_pop;

    assign full    = (count_reg == (fbr_pkg::QPTR_W+1)'(fbr_pkg::Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/fbr_front.sv =====
module fbr_front #(
    parameter int MAX_BLOCK = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [1:0]    kind,
    input  logic [7:0]    rx_byte,
    input  logic          q_full,
    input  logic          commit_done,
    output logic          push,
    output fbr_pkg::cmd_t cmd,
    output fbr_pkg::wr_t  wr
);

    localparam logic [7:0] MAX_LEN = 8'(MAX_BLOCK);

    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_COLON = 8'b0000_0010,
        PH_LEN   = 8'b0000_0100,
        PH_ALO   = 8'b0000_1000,
        PH_AHI   = 8'b0001_0000,
        PH_SUM   = 8'b0010_0000,
        PH_DATA  = 8'b0100_0000,
        PH_HALT  = 8'b1000_0000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  block_len_reg, block_len_next;
    logic [15:0] page_addr_reg, page_addr_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic        commit_pending_reg, commit_pending_next;

    logic       accept;
    logic [7:0] sum_base;
    logic [7:0] frame_sum;
    logic [7:0] count_inc;

    assign in_stall  = q_full || commit_pending_reg;
    assign accept    = in_valid && !in_stall;
    assign sum_base  = (phase_reg == PH_DATA) ? running_sum_reg : 8'd0;
    assign frame_sum = sum_base + rx_byte + block_len_reg
                       + page_addr_reg[7:0] + page_addr_reg[15:8];
    assign count_inc = byte_count_reg + 8'd1;

    always_comb
    begin
        phase_next          = phase_reg;
        block_len_next      = block_len_reg;
        page_addr_next      = page_addr_reg;
        running_sum_next    = running_sum_reg;
        byte_count_next     = byte_count_reg;
        commit_pending_next = commit_pending_reg;
        push                = 1'b0;
        cmd                 = '0;
        wr                  = '0;

        if (commit_done)
        begin
            commit_pending_next = 1'b0;
        end

        if (accept && phase_reg != PH_HALT)
        begin
            case (kind)
                fbr_pkg::KIND_BEGIN:
                begin
                    phase_next       = PH_COLON;
                    running_sum_next = 8'd0;
                    byte_count_next  = 8'd0;
                    push             = 1'b1;
                    cmd.op           = fbr_pkg::CMD_SEND;
                    cmd.tx           = fbr_pkg::CH_T;
                end
                fbr_pkg::KIND_TIMEOUT:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        phase_next = PH_COLON;
                        push       = 1'b1;
                        cmd.op     = fbr_pkg::CMD_SEND;
                        cmd.tx     = fbr_pkg::CH_X;
                    end
                end
                fbr_pkg::KIND_BYTE:
                begin
                    case (phase_reg)
                        PH_COLON:
                        begin
                            if (rx_byte == fbr_pkg::CH_COLON)
                            begin
                                phase_next = PH_LEN;
                            end
                        end
                        PH_LEN:
                        begin
                            if (rx_byte == fbr_pkg::CH_S)
                            begin
                                phase_next = PH_HALT;
                                push       = 1'b1;
                                cmd.op     = fbr_pkg::CMD_START;
                            end
                            else if (rx_byte > MAX_LEN)
                            begin
                                phase_next = PH_COLON;
                                push       = 1'b1;
                                cmd.op     = fbr_pkg::CMD_SEND;
                                cmd.tx     = fbr_pkg::CH_X;
                            end
                            else
                            begin
                                block_len_next = rx_byte;
                                phase_next     = PH_ALO;
                            end
                        end
                        PH_ALO:
                        begin
                            page_addr_next = {page_addr_reg[15:8], rx_byte};
                            phase_next     = PH_AHI;
                        end
                        PH_AHI:
                        begin
                            page_addr_next = {rx_byte, page_addr_reg[7:0]};
                            phase_next     = PH_SUM;
                            push           = 1'b1;
                            cmd.op         = fbr_pkg::CMD_ERASE;
                            cmd.addr       = {rx_byte, page_addr_reg[7:0]};
                        end
                        PH_SUM, PH_DATA:
                        begin
                            if (phase_reg == PH_SUM)
                            begin
                                running_sum_next = rx_byte;
                                byte_count_next  = 8'd0;
                            end
                            else
                            begin
                                wr.en            = 1'b1;
                                wr.idx           = byte_count_reg;
                                wr.data          = rx_byte;
                                running_sum_next = running_sum_reg + rx_byte;
                                byte_count_next  = count_inc;
                            end
                            if ((phase_reg == PH_SUM && block_len_reg == 8'd0)
                                || (phase_reg == PH_DATA && count_inc >= block_len_reg))
                            begin
                                // frame complete
                                phase_next = PH_COLON;
                                push       = 1'b1;
                                if (frame_sum == 8'd0)
                                begin
                                    cmd.op              = fbr_pkg::CMD_COMMIT;
                                    cmd.addr            = page_addr_reg;
                                    cmd.len             = block_len_reg;
                                    commit_pending_next = 1'b1;
                                end
                                else
                                begin
                                    cmd.op = fbr_pkg::CMD_SEND;
                                    cmd.tx = fbr_pkg::CH_X;
                                end
                            end
                            else if (phase_reg == PH_SUM)
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            block_len_reg      <= '0;
            page_addr_reg      <= '0;
            running_sum_reg    <= '0;
            byte_count_reg     <= '0;
            commit_pending_reg <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            block_len_reg      <= block_len_next;
            page_addr_reg      <= page_addr_next;
            running_sum_reg    <= running_sum_next;
            byte_count_reg     <= byte_count_next;
            commit_pending_reg <= commit_pending_next;
        end
    end

endmodule

// ===== src/fbr_back.sv =====
module fbr_back #(
    parameter int MAX_BLOCK = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    output logic          q_pop,
    input  fbr_pkg::cmd_t q_cmd,
    input  fbr_pkg::wr_t  wr,
    output logic          commit_done,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [2:0]    action,
    output logic [7:0]    tx_byte,
    output logic [15:0]   address,
    output logic [15:0]   word_data,
    output logic          last
);

    localparam int         AW      = $clog2(MAX_BLOCK);
    localparam logic [7:0] MAX_LEN = 8'(MAX_BLOCK);

    typedef enum logic [5:0] {
        B_IDLE  = 6'b00_0001,
        B_LO    = 6'b00_0010,
        B_HI    = 6'b00_0100,
        B_FILL  = 6'b00_1000,
        B_WRITE = 6'b01_0000,
        B_TACK  = 6'b10_0000
    } bstate_t;

    logic [7:0] page_mem [MAX_BLOCK];

    bstate_t     state_reg, state_next;
    logic [7:0]  idx_reg, idx_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] base_reg, base_next;
    logic [7:0]  lo_reg, lo_next;
    logic [7:0]  rd_data_reg;

    logic        ov_reg, ov_next;
    logic [2:0]  act_reg, act_next;
    logic [7:0]  tx_reg, tx_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] word_reg, word_next;
    logic        last_reg, last_next;

    logic        out_free;
    logic [7:0]  idx_inc;
    logic [7:0]  idx_step;
    logic [7:0]  rd_sel;
    logic [AW-1:0] rd_idx;
    logic        ld;
    logic [2:0]  ld_act;
    logic [7:0]  ld_tx;
    logic [15:0] ld_addr;
    logic [15:0] ld_word;
    logic        ld_last;

    assign out_free = !ov_reg || !out_stall;
    assign idx_inc  = idx_reg + 8'd1;
    assign idx_step = idx_reg + 8'd2;
    assign rd_sel   = (state_reg == B_LO) ? idx_reg : idx_inc;
    assign rd_idx   = (rd_sel < MAX_LEN) ? rd_sel[AW-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.idx < MAX_LEN)
        begin
            page_mem[wr.idx[AW-1:0]] <= wr.data;
        end
        rd_data_reg <= page_mem[rd_idx];
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        base_next   = base_reg;
        lo_next     = lo_reg;
        q_pop       = 1'b0;
        commit_done = 1'b0;
        ld          = 1'b0;
        ld_act      = fbr_pkg::ACT_SEND;
        ld_tx       = 8'd0;
        ld_addr     = 16'd0;
        ld_word     = 16'd0;
        ld_last     = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (out_free && !q_empty)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.op)
                        fbr_pkg::CMD_SEND:
                        begin
                            ld      = 1'b1;
                            ld_act  = fbr_pkg::ACT_SEND;
                            ld_tx   = q_cmd.tx;
                            ld_last = 1'b1;
                        end
                        fbr_pkg::CMD_ERASE:
                        begin
                            ld      = 1'b1;
                            ld_act  = fbr_pkg::ACT_ERASE;
                            ld_addr = q_cmd.addr;
                            ld_last = 1'b1;
                        end
                        fbr_pkg::CMD_START:
                        begin
                            ld      = 1'b1;
                            ld_act  = fbr_pkg::ACT_START;
                            ld_last = 1'b1;
                        end
                        fbr_pkg::CMD_COMMIT:
                        begin
                            base_next  = q_cmd.addr;
                            len_next   = q_cmd.len;
                            idx_next   = 8'd0;
                            state_next = (q_cmd.len == 8'd0) ? B_WRITE : B_LO;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            B_LO:
            begin
                state_next = B_HI;
            end
            B_HI:
            begin
                lo_next    = rd_data_reg;
                state_next = B_FILL;
            end
            B_FILL:
            begin
                if (out_free)
                begin
                    ld      = 1'b1;
                    ld_act  = fbr_pkg::ACT_FILL;
                    ld_addr = base_reg + {8'd0, idx_reg};
                    // odd length: missing high byte reads as zero
                    ld_word = {(idx_inc < len_reg) ? rd_data_reg : 8'd0, lo_reg};
                    idx_next   = idx_step;
                    state_next = (idx_step < len_reg) ? B_LO : B_WRITE;
                end
            end
            B_WRITE:
            begin
                if (out_free)
                begin
                    ld         = 1'b1;
                    ld_act     = fbr_pkg::ACT_WRITE;
                    ld_addr    = base_reg;
                    state_next = B_TACK;
                end
            end
            B_TACK:
            begin
                if (out_free)
                begin
                    ld          = 1'b1;
                    ld_act      = fbr_pkg::ACT_SEND;
                    ld_tx       = fbr_pkg::CH_T;
                    ld_last     = 1'b1;
                    commit_done = 1'b1;
                    state_next  = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ov_next   = ov_reg;
        act_next  = act_reg;
        tx_next   = tx_reg;
        addr_next = addr_reg;
        word_next = word_reg;
        last_next = last_reg;
        if (out_free)
        begin
            ov_next = 1'b0;
        end
        if (ld)
        begin
            ov_next   = 1'b1;
            act_next  = ld_act;
            tx_next   = ld_tx;
            addr_next = ld_addr;
            word_next = ld_word;
            last_next = ld_last;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        len_reg  <= len_next;
        base_reg <= base_next;
        lo_reg   <= lo_next;
        act_reg  <= act_next;
        tx_reg   <= tx_next;
        addr_reg <= addr_next;
        word_reg <= word_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;
    assign action    = act_reg;
    assign tx_byte   = tx_reg;
    assign address   = addr_reg;
    assign word_data = word_reg;
    assign last      = last_reg;

endmodule

// ===== src/flash_block_receiver_unit.sv =====
// Flash block receiver.
// Input channel (in_valid/in_stall): one item per serial event, kind 0 a
// received byte in rx_byte, kind 1 a receive timeout, kind 2 begin session.
// Output channel (out_valid/out_stall): result items (send byte, erase page,
// fill word, write page, start application); last marks the final item
// caused by one input item.
// The front takes one input item per cycle while in_stall is low and passes at most
// one command per item through a two-entry queue to the back. Send, erase and
// start results pass through the queue and the back's output register. A good
// frame of N data bytes expands in the back into ceil(N/2) fills, each through B_LO,
// B_HI and B_FILL (two page buffer reads per word), then the page write and 'T'.
// in_stall rises when the queue is full and from the acceptance of a good
// frame until its 'T' has been loaded, so a commit burst never races the
// next frame's data into the page buffer.
// A stalled output holds its item; the queue lets the front run ahead.
// Reset puts the block idle, waiting for a begin item; the page buffer is
// not cleared and needs no clearing pass.
`include "flash_block_receiver_unit_defines.svh"

module flash_block_receiver_unit #(
    parameter int MAX_BLOCK = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  action,
    output logic [7:0]  tx_byte,
    output logic [15:0] address,
    output logic [15:0] word_data,
    output logic        last
);

    fbr_pkg::cmd_t push_cmd;
    fbr_pkg::cmd_t pop_cmd;
    fbr_pkg::wr_t  wr;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    logic          commit_done;

    fbr_front #(
        .MAX_BLOCK(MAX_BLOCK)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .rx_byte    (rx_byte),
        .q_full     (q_full),
        .commit_done(commit_done),
        .push       (push),
        .cmd        (push_cmd),
        .wr         (wr)
    );

    fbr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_cmd(push_cmd),
        .pop     (pop),
        .pop_cmd (pop_cmd),
        .full    (q_full),
        .empty   (q_empty)
    );

    fbr_back #(
        .MAX_BLOCK(MAX_BLOCK)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop      (pop),
        .q_cmd      (pop_cmd),
        .wr         (wr),
        .commit_done(commit_done),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .action     (action),
        .tx_byte    (tx_byte),
        .address    (address),
        .word_data  (word_data),
        .last       (last)
    );

    `FBR_ASSERT(a_fill_holds_input, clk, rst_n, (out_valid && action == fbr_pkg::ACT_FILL) |-> in_stall, "fill shown while input open")
    `FBR_ASSERT(a_not_last_is_commit, clk, rst_n, (out_valid && !last) |-> (action == fbr_pkg::ACT_FILL || action == fbr_pkg::ACT_WRITE), "non-final item outside a commit")
    `FBR_ASSERT(a_tx_only_on_send, clk, rst_n, (out_valid && action != fbr_pkg::ACT_SEND) |-> (tx_byte == 8'd0), "tx byte set on non-send item")
    `FBR_ASSERT_NEXT(a_write_then_ack, clk, rst_n, out_valid && !out_stall && action == fbr_pkg::ACT_WRITE, out_valid && action == fbr_pkg::ACT_SEND && tx_byte == fbr_pkg::CH_T && last, "page write not followed by T")

endmodule

// ===== bench/flash_block_receiver_unit_tb.sv =====
`timescale 1ns / 1ps

module flash_block_receiver_unit_tb;

    localparam int FRAME_MAX = 64;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [1:0] KIND_RSVD = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE, PH_COLON, PH_LEN, PH_ALO, PH_AHI, PH_SUM, PH_DATA, PH_HALT
    } rx_phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } serial_event_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  tx;
        logic [15:0] addr;
        logic [15:0] wdata;
        logic        last;
    } flash_op_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  kind;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  action;
    logic [7:0]  tx_byte;
    logic [15:0] address;
    logic [15:0] word_data;
    logic        last;

    flash_block_receiver_unit #(.MAX_BLOCK(FRAME_MAX)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .action    (action),
        .tx_byte   (tx_byte),
        .address   (address),
        .word_data (word_data),
        .last      (last)
    );

    // receiver state as predicted
    rx_phase_t   rx_phase;
    logic [7:0]  blk_len;
    logic [15:0] blk_addr;
    logic [7:0]  sum_acc;
    logic [7:0]  byte_cnt;
    logic [7:0]  page_mem [FRAME_MAX];

    serial_event_t event_q[$];
    flash_op_t     expected_ops[$];
    flash_op_t     op_burst[$];

    logic in_took;
    logic out_took;
    int   in_gap;
    int   out_wait;
    bit   in_burst;
    bit   out_burst;
    int   mismatches;
    int   idle_cycles;

    function automatic void note_op(logic [2:0] act, logic [7:0] tx, logic [15:0] a,
                                    logic [15:0] w);
        flash_op_t op;
        op.action = act;
        op.tx     = tx;
        op.addr   = a;
        op.wdata  = w;
        op.last   = 1'b0;
        op_burst.push_back(op);
    endfunction

    function automatic void commit_page();
        logic [7:0]  total;
        logic [15:0] w;
        total = sum_acc + blk_len + blk_addr[7:0] + blk_addr[15:8];
        if (total == 8'd0)
        begin
            for (int i = 0; i < blk_len; i += 2)
            begin
                w = {((i + 1 < blk_len) ? page_mem[i + 1] : 8'h00), page_mem[i]};
                note_op(fbr_pkg::ACT_FILL, 8'h00, blk_addr + 16'(i), w);
            end
            note_op(fbr_pkg::ACT_WRITE, 8'h00, blk_addr, 16'h0000);
            note_op(fbr_pkg::ACT_SEND, fbr_pkg::CH_T, 16'h0000, 16'h0000);
        end
        else
        begin
            note_op(fbr_pkg::ACT_SEND, fbr_pkg::CH_X, 16'h0000, 16'h0000);
        end
        rx_phase = PH_COLON;
    endfunction

    function automatic void predict_event(logic [1:0] k, logic [7:0] b);
        flash_op_t op;
        op_burst.delete();
        if (rx_phase != PH_HALT)
        begin
            if (k == fbr_pkg::KIND_BEGIN)
            begin
                rx_phase = PH_COLON;
                sum_acc  = 8'h00;
                byte_cnt = 8'h00;
                note_op(fbr_pkg::ACT_SEND, fbr_pkg::CH_T, 16'h0000, 16'h0000);
            end
            else if (k == fbr_pkg::KIND_TIMEOUT)
            begin
                if (rx_phase != PH_IDLE)
                begin
                    rx_phase = PH_COLON;
                    note_op(fbr_pkg::ACT_SEND, fbr_pkg::CH_X, 16'h0000, 16'h0000);
                end
            end
            else if (k == fbr_pkg::KIND_BYTE)
            begin
                case (rx_phase)
                    PH_COLON:
                        if (b == fbr_pkg::CH_COLON)
                            rx_phase = PH_LEN;
                    PH_LEN:
                        if (b == fbr_pkg::CH_S)
                        begin
                            rx_phase = PH_HALT;
                            note_op(fbr_pkg::ACT_START, 8'h00, 16'h0000, 16'h0000);
                        end
                        else if (b > FRAME_MAX)
                        begin
                            rx_phase = PH_COLON;
                            note_op(fbr_pkg::ACT_SEND, fbr_pkg::CH_X, 16'h0000, 16'h0000);
                        end
                        else
                        begin
                            blk_len  = b;
                            rx_phase = PH_ALO;
                        end
                    PH_ALO:
                    begin
                        blk_addr[7:0] = b;
                        rx_phase = PH_AHI;
                    end
                    PH_AHI:
                    begin
                        blk_addr[15:8] = b;
                        rx_phase = PH_SUM;
                        note_op(fbr_pkg::ACT_ERASE, 8'h00, blk_addr, 16'h0000);
                    end
                    PH_SUM:
                    begin
                        sum_acc  = b;
                        byte_cnt = 8'h00;
                        if (blk_len == 8'h00)
                            commit_page();
                        else
                            rx_phase = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        if (byte_cnt < FRAME_MAX)
                            page_mem[byte_cnt] = b;
                        sum_acc  = sum_acc + b;
                        byte_cnt = byte_cnt + 8'h01;
                        if (byte_cnt >= blk_len)
                            commit_page();
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        if (op_burst.size() > 0)
        begin
            op = op_burst.pop_back();
            op.last = 1'b1;
            op_burst.push_back(op);
        end
        foreach (op_burst[i])
            expected_ops.push_back(op_burst[i]);
    endfunction

    function automatic void push_event(logic [1:0] k, logic [7:0] b);
        serial_event_t ev;
        ev.kind = k;
        ev.data = b;
        event_q.push_back(ev);
    endfunction

    // keep < 0 sends the whole frame; spoil corrupts the checksum
    function automatic void push_frame(int len, logic [15:0] a, int keep, bit spoil);
        logic [7:0] body[$];
        logic [7:0] chk;
        logic [7:0] d;
        chk = 8'(len) + a[7:0] + a[15:8];
        body.push_back(fbr_pkg::CH_COLON);
        body.push_back(8'(len));
        body.push_back(a[7:0]);
        body.push_back(a[15:8]);
        body.push_back(8'h00);
        for (int i = 0; i < len; i++)
        begin
            d = 8'($urandom);
            chk = chk + d;
            body.push_back(d);
        end
        chk = -chk;
        if (spoil)
            chk = chk ^ 8'($urandom_range(1, 255));
        body[4] = chk;
        if (keep < 0)
            keep = body.size();
        for (int i = 0; i < keep; i++)
            push_event(fbr_pkg::KIND_BYTE, body[i]);
    endfunction

    function automatic void build_stimulus();
        int pick;
        int len;
        int v;
        // idle: ignored until a begin
        push_event(fbr_pkg::KIND_BYTE, fbr_pkg::CH_COLON);
        push_event(fbr_pkg::KIND_TIMEOUT, 8'h00);
        push_event(KIND_RSVD, 8'hFF);
        push_event(fbr_pkg::KIND_BEGIN, 8'h00);
        push_event(fbr_pkg::KIND_TIMEOUT, 8'hA5);
        push_event(fbr_pkg::KIND_BYTE, 8'hFF);
        push_frame(0, 16'hFFFF, -1, 1'b0);
        push_frame(3, 16'hFFFE, -1, 1'b0);
        push_event(fbr_pkg::KIND_BYTE, fbr_pkg::CH_COLON);
        push_event(fbr_pkg::KIND_BYTE, 8'hFF);
        push_event(fbr_pkg::KIND_BYTE, fbr_pkg::CH_COLON);
        push_event(fbr_pkg::KIND_BYTE, 8'(FRAME_MAX + 1));
        push_event(KIND_RSVD, 8'h00);
        push_frame(5, 16'h1234, 2, 1'b0);
        push_event(fbr_pkg::KIND_BEGIN, 8'hFF);

        push_frame(FRAME_MAX, 16'($urandom), -1, 1'b0);
        while (event_q.size() < 220)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                v = $urandom_range(0, 19);
                len = (v < 16) ? $urandom_range(0, 8)
                    : (v < 19) ? $urandom_range(9, 40) : $urandom_range(41, FRAME_MAX);
            end
            else
            begin
                len = $urandom_range(0, 12);
            end
            if (pick < 62)
                push_frame(len, 16'($urandom), -1, 1'b0);
            else if (pick < 72)
                push_frame(len, 16'($urandom), -1, 1'b1);
            else if (pick < 77)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    do
                        v = $urandom_range(0, 255);
                    while (v == fbr_pkg::CH_COLON);
                    push_event(fbr_pkg::KIND_BYTE, 8'(v));
                end
            end
            else if (pick < 83)
            begin
                push_frame(len, 16'($urandom), $urandom_range(1, 4 + len), 1'b0);
                push_event(fbr_pkg::KIND_TIMEOUT, 8'($urandom));
            end
            else if (pick < 88)
            begin
                push_frame(len, 16'($urandom), $urandom_range(1, 4 + len), 1'b0);
                push_event(fbr_pkg::KIND_BEGIN, 8'($urandom));
            end
            else if (pick < 93)
            begin
                do
                    v = $urandom_range(FRAME_MAX + 1, 255);
                while (v == fbr_pkg::CH_S);
                push_event(fbr_pkg::KIND_BYTE, fbr_pkg::CH_COLON);
                push_event(fbr_pkg::KIND_BYTE, 8'(v));
            end
            else if (pick < 96)
                push_event(fbr_pkg::KIND_TIMEOUT, 8'($urandom));
            else if (pick < 98)
                push_event(KIND_RSVD, 8'($urandom));
            else
                push_event(fbr_pkg::KIND_BEGIN, 8'($urandom));
        end

        // start application, then everything is ignored
        push_event(fbr_pkg::KIND_BYTE, fbr_pkg::CH_COLON);
        push_event(fbr_pkg::KIND_BYTE, fbr_pkg::CH_S);
        push_event(fbr_pkg::KIND_BEGIN, 8'h00);
        push_event(fbr_pkg::KIND_BYTE, fbr_pkg::CH_COLON);
        push_event(fbr_pkg::KIND_TIMEOUT, 8'h00);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin : monitor
        flash_op_t want;
        flash_op_t got;
        if (rst_n)
        begin
            in_took  = in_valid && !in_stall;
            out_took = out_valid && !out_stall;
            if (in_took)
                predict_event(kind, rx_byte);
            if (out_took)
            begin
                got.action = action;
                got.tx     = tx_byte;
                got.addr   = address;
                got.wdata  = word_data;
                got.last   = last;
                if (expected_ops.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected item: action %0d tx %h addr %h word %h last %b",
                                 got.action, got.tx, got.addr, got.wdata, got.last);
                    mismatches++;
                end
                else
                begin
                    want = expected_ops.pop_front();
                    if (got.action !== want.action || got.tx !== want.tx ||
                        got.addr !== want.addr || got.wdata !== want.wdata ||
                        got.last !== want.last)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("mismatch: exp action %0d tx %h addr %h word %h last %b",
                                     want.action, want.tx, want.addr, want.wdata, want.last);
                            $display("          got action %0d tx %h addr %h word %h last %b",
                                     got.action, got.tx, got.addr, got.wdata, got.last);
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin : drive_events
        serial_event_t ev;
        if (rst_n && !(in_valid && !in_took))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (event_q.size() > 0)
            begin
                ev = event_q.pop_front();
                kind     <= ev.kind;
                rx_byte  <= ev.data;
                in_valid <= 1'b1;
                if ($urandom_range(0, 31) == 0)
                    in_burst = !in_burst;
                in_gap = in_burst ? 0 : $urandom_range(0, 8);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : drive_stall
        if (rst_n)
        begin
            if (out_took)
            begin
                if ($urandom_range(0, 31) == 0)
                    out_burst = !out_burst;
                out_wait = out_burst ? 0 : $urandom_range(0, 8);
            end
            if (out_wait > 0)
            begin
                out_wait--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL flash_block_receiver_unit");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = fbr_pkg::KIND_BYTE;
        rx_byte     = 8'h00;
        out_stall   = 1'b0;
        in_took     = 1'b0;
        out_took    = 1'b0;
        in_gap      = 0;
        out_wait    = 0;
        in_burst    = 1'b0;
        out_burst   = 1'b0;
        mismatches  = 0;
        idle_cycles = 0;
        rx_phase    = PH_IDLE;
        blk_len     = 8'h00;
        blk_addr    = 16'h0000;
        sum_acc     = 8'h00;
        byte_cnt    = 8'h00;
        build_stimulus();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (event_q.size() > 0 || in_valid)
            @(negedge clk);
        while (expected_ops.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("PASS flash_block_receiver_unit");
        else
            $display("FAIL flash_block_receiver_unit");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/fbr_pkg.sv
src/fbr_queue.sv
src/fbr_front.sv
src/fbr_back.sv
src/flash_block_receiver_unit.sv
bench/flash_block_receiver_unit_tb.sv
